FILE: design/uvc_pkg.sv
// Shared types and constants for the unsigned LEB128 varint codec.
package uvc_pkg;

    localparam int MaxBytes  = 10;
    localparam int CountW    = 4;
    localparam int ValueW    = 64;
    localparam int GroupW    = 7;
    localparam int ShiftW    = 6;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [AddrW-1:0] REG_LIMIT_ADDR = 3'd0;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef enum logic
    {
        KIND_ENC_BYTE = 1'b0,
        KIND_DEC_OUT  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_TOO_LONG  = 2'd3
    } status_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_ENC  = 1'b1
    } seq_state_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } enc_out_t;

    typedef struct packed
    {
        logic              emit;
        logic [ValueW-1:0] value;
        logic [CountW-1:0] count;
        status_t           status;
    } dec_out_t;

endpackage

FILE: design/uvc_enc_unit.sv
// Encoder: 64-bit shift register stepped 7 bits per emitted byte.
module uvc_enc_unit
    import uvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [ValueW-1:0] value,
    input  logic              step,
    output enc_out_t          enc_out
);

    logic [ValueW-1:0] shift_reg;
    logic [ValueW-1:0] shift_next;
    logic [CountW-1:0] cnt_reg;
    logic [CountW-1:0] cnt_next;
    logic              final_byte;

    assign final_byte = (shift_reg[ValueW-1:GroupW] == '0) ||
                        (cnt_reg == CountW'(MaxBytes - 1));

    always_comb
    begin
        enc_out.last = final_byte;
        if (final_byte)
        begin
            enc_out.data = shift_reg[7:0];
        end
        else
        begin
            enc_out.data = {1'b1, shift_reg[GroupW-1:0]};
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            shift_next = value;
            cnt_next   = '0;
        end
        else if (step)
        begin
            shift_next = shift_reg >> GroupW;
            cnt_next   = cnt_reg + CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

FILE: design/uvc_dec_unit.sv
// Decoder: accumulates 7-bit groups and classifies the finished varint.
module uvc_dec_unit
    import uvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       buffer_end,
    input  logic       limit_32,
    output dec_out_t   dec_out
);

    logic [ValueW-1:0] acc_reg;
    logic [ValueW-1:0] acc_next;
    logic [CountW-1:0] seen_reg;
    logic [CountW-1:0] seen_next;
    logic [ShiftW-1:0] shamt_reg;
    logic [ShiftW-1:0] shamt_next;
    logic [ValueW-1:0] acc_sum;
    logic [CountW-1:0] n;
    logic              tenth;
    status_t           st;
    logic              done;

    assign acc_sum = acc_reg | ({{(ValueW-GroupW){1'b0}}, in_byte[GroupW-1:0]} << shamt_reg);
    assign n       = seen_reg + CountW'(1);
    assign tenth   = (seen_reg == CountW'(MaxBytes - 1));

    always_comb
    begin
        st   = STATUS_OK;
        done = 1'b1;
        if (in_byte[7])
        begin
            priority if (tenth)
            begin
                st = STATUS_TOO_LONG;
            end
            else if (buffer_end)
            begin
                st = STATUS_TRUNCATED;
            end
            else
            begin
                done = 1'b0;
            end
        end
        else
        begin
            priority if (tenth && (in_byte > 8'd1))
            begin
                st = STATUS_OVERFLOW;
            end
            else if (limit_32 && (acc_sum[ValueW-1:32] != '0))
            begin
                st = STATUS_OVERFLOW;
            end
            else
            begin
                st = STATUS_OK;
            end
        end
    end

    always_comb
    begin
        dec_out.emit   = step && done;
        dec_out.status = st;
        if (st == STATUS_OK)
        begin
            dec_out.value = acc_sum;
            dec_out.count = n;
        end
        else
        begin
            dec_out.value = '0;
            dec_out.count = '0;
        end
    end

    always_comb
    begin
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        shamt_next = shamt_reg;
        if (step)
        begin
            if (done)
            begin
                acc_next   = '0;
                seen_next  = '0;
                shamt_next = '0;
            end
            else
            begin
                acc_next   = acc_sum;
                seen_next  = n;
                shamt_next = shamt_reg + ShiftW'(GroupW);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            seen_reg  <= '0;
            shamt_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            shamt_reg <= shamt_next;
        end
    end

endmodule

FILE: design/uvarint_codec.sv
// Decode: one byte per cycle unless stalled; outcome registered the next cycle.
// Encode: value of N bytes (1 to 10), one byte per cycle unless the output
//   stalls, from the encoder's 64-bit shift register via the output register.
// Input stalls while encoding or while the output register is full and stalled.
// Reset (rst_n low, async) clears sequencer, accumulator, counters and config.
module uvarint_codec
    import uvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [ValueW-1:0] value,
    input  logic [7:0]        in_byte,
    input  logic              buffer_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              kind,
    output logic [7:0]        out_byte,
    output logic [ValueW-1:0] out_value,
    output logic [CountW-1:0] byte_count,
    output logic [1:0]        status,
    output logic              last
);

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic              limit_reg;
    logic              limit_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              kind_reg;
    logic [7:0]        byte_reg;
    logic [ValueW-1:0] value_reg;
    logic [CountW-1:0] count_reg;
    logic [1:0]        status_reg;
    logic              last_reg;
    logic              out_free;
    logic              in_xfer;
    logic              enc_load;
    logic              enc_step;
    logic              dec_step;
    enc_out_t          enc_out;
    dec_out_t          dec_out;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[AddrW-1] == REG_LIMIT_ADDR[AddrW-1]) ?
                    {{(DataW-1){1'b0}}, limit_reg} : '0;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && (paddr[AddrW-1] == REG_LIMIT_ADDR[AddrW-1]))
        begin
            limit_next = pwdata[0];
        end
    end

    // sequencer
    assign out_free = !out_valid_reg || !out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (cmd == CMD_ENCODE))
                begin
                    state_next = ST_ENC;
                end
            end
            ST_ENC:
            begin
                if (out_free && enc_out.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        enc_load = 1'b0;
        enc_step = 1'b0;
        dec_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !out_free;
                enc_load = in_valid && out_free && (cmd == CMD_ENCODE);
                dec_step = in_valid && out_free && (cmd == CMD_DECODE);
            end
            ST_ENC:
            begin
                enc_step = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    uvc_enc_unit u_enc
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (enc_load),
        .value   (value),
        .step    (enc_step),
        .enc_out (enc_out)
    );

    uvc_dec_unit u_dec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (dec_step),
        .in_byte    (in_byte),
        .buffer_end (buffer_end),
        .limit_32   (limit_reg),
        .dec_out    (dec_out)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (enc_step || dec_out.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enc_step)
        begin
            kind_reg   <= KIND_ENC_BYTE;
            byte_reg   <= enc_out.data;
            value_reg  <= '0;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
            last_reg   <= enc_out.last;
        end
        else if (dec_out.emit)
        begin
            kind_reg   <= KIND_DEC_OUT;
            byte_reg   <= '0;
            value_reg  <= dec_out.value;
            count_reg  <= dec_out.count;
            status_reg <= dec_out.status;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_byte   = byte_reg;
    assign out_value  = value_reg;
    assign byte_count = count_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    a_enc_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENC) |-> in_stall)
        else $error("input taken while encoding");

    a_enc_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (cmd == CMD_ENCODE)) |=> (state_reg == ST_ENC))
        else $error("encode transfer did not start encoder");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_DEC_OUT) && (status != STATUS_OK))
        |-> ((byte_count == '0) && (out_value == '0) && last))
        else $error("error outcome carries value or count");

    a_enc_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_ENC_BYTE) && !last) |-> out_byte[7])
        else $error("non-final encoded byte lacks continuation bit");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the unsigned LEB128 varint encoder and decoder.
`timescale 1ns / 1ps

module testbench;
    import uvc_pkg::*;

    localparam int HalfPeriod   = 6;
    localparam int ResetCycles  = 4;
    localparam int SettleCycles = 20;
    localparam int HoldCycles   = 300;
    localparam int StallLimit   = 3000;
    localparam int PhaseItems   = 113;
    localparam int MaxReports   = 40;

    typedef struct packed
    {
        kind_t             kind;
        logic [7:0]        data;
        logic [ValueW-1:0] value;
        logic [CountW-1:0] count;
        status_t           status;
        logic              last;
    } codec_result_t;

    typedef struct
    {
        logic              limit32;
        cmd_t              cmd;
        logic [ValueW-1:0] value;
        logic [7:0]        in_byte;
        logic              buffer_end;
        int                reps;
        logic              typed;
        codec_result_t     want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              cmd;
    logic [ValueW-1:0] value;
    logic [7:0]        in_byte;
    logic              buffer_end;
    logic              out_valid;
    logic              out_stall;
    logic              kind;
    logic [7:0]        out_byte;
    logic [ValueW-1:0] out_value;
    logic [CountW-1:0] byte_count;
    logic [1:0]        status;
    logic              last;

    // predictor state
    logic [ValueW-1:0] dec_acc;
    logic [CountW-1:0] dec_seen;
    logic              limit32;
    codec_result_t     model_out [0:MaxBytes-1];
    int                model_count;

    codec_result_t     pending_results [$];
    stim_row_t         directed_rows [$];
    logic              use_typed;
    codec_result_t     typed_want;
    int                mismatches;
    int                items_offered;
    int                burst_left;
    logic              hold_pending;

    uvarint_codec DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #HalfPeriod clk = ~clk;
    end

    function automatic codec_result_t make_result(input kind_t k, input logic [7:0] d,
                                                  input logic [ValueW-1:0] v,
                                                  input logic [CountW-1:0] n,
                                                  input status_t s, input logic l);
        codec_result_t r;
        r.kind   = k;
        r.data   = d;
        r.value  = v;
        r.count  = n;
        r.status = s;
        r.last   = l;
        return r;
    endfunction

    function automatic stim_row_t stim_row(input logic lim, input cmd_t c,
                                           input logic [ValueW-1:0] v, input logic [7:0] b,
                                           input logic e, input int reps, input logic typed,
                                           input codec_result_t want);
        stim_row_t r;
        r.limit32    = lim;
        r.cmd        = c;
        r.value      = v;
        r.in_byte    = b;
        r.buffer_end = e;
        r.reps       = reps;
        r.typed      = typed;
        r.want       = want;
        return r;
    endfunction

    task automatic compute_codec_results(input cmd_t c, input logic [ValueW-1:0] v,
                                         input logic [7:0] b, input logic e);
        logic [ValueW-1:0] rem;
        logic [CountW-1:0] n;
        status_t           st;
        logic              emit;
        int                k;
        int                shift;
        model_count = 0;
        if (c == CMD_ENCODE)
        begin
            rem = v;
            k = 0;
            while (rem >= 64'h80 && k < MaxBytes - 1)
            begin
                model_out[k] = make_result(KIND_ENC_BYTE, {1'b1, rem[6:0]}, 64'd0, 4'd0,
                                           STATUS_OK, 1'b0);
                rem = rem >> GroupW;
                k++;
            end
            model_out[k] = make_result(KIND_ENC_BYTE, rem[7:0], 64'd0, 4'd0, STATUS_OK, 1'b1);
            model_count = k + 1;
        end
        else
        begin
            shift = GroupW * dec_seen;
            if (shift < ValueW)
                dec_acc = dec_acc | ({57'd0, b[6:0]} << shift);
            n = dec_seen + 4'd1;
            st = STATUS_OK;
            emit = 1'b1;
            if (b[7])
            begin
                if (n >= MaxBytes)
                    st = STATUS_TOO_LONG;
                else if (e)
                    st = STATUS_TRUNCATED;
                else
                begin
                    dec_seen = n;
                    emit = 1'b0;
                end
            end
            else if (n >= MaxBytes && b > 8'd1)
                st = STATUS_OVERFLOW;
            else if (limit32 && dec_acc > 64'hFFFF_FFFF)
                st = STATUS_OVERFLOW;
            if (emit)
            begin
                if (st == STATUS_OK)
                    model_out[0] = make_result(KIND_DEC_OUT, 8'h00, dec_acc, n, STATUS_OK, 1'b1);
                else
                    model_out[0] = make_result(KIND_DEC_OUT, 8'h00, 64'd0, 4'd0, st, 1'b1);
                model_count = 1;
                dec_acc = '0;
                dec_seen = '0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input codec_result_t want,
                                   input codec_result_t got);
        string want_txt;
        mismatches++;
        if (mismatches <= MaxReports)
        begin
            want_txt = $sformatf("kind=%0d byte=%h value=%h count=%0d status=%0d last=%0b",
                                 want.kind, want.data, want.value, want.count, want.status,
                                 want.last);
            $display("%0t mismatch, %s: want %s, got kind=%0d byte=%h value=%h count=%0d %s%0d %s%0b",
                     $time, what, want_txt, got.kind, got.data, got.value, got.count,
                     "status=", got.status, "last=", got.last);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        codec_result_t got;
        codec_result_t want;
        int i;
        if (out_valid && !out_stall)
        begin
            got = make_result(kind_t'(kind), out_byte, out_value, byte_count,
                              status_t'(status), last);
            if (pending_results.size() == 0)
                report_mismatch("transfer with nothing expected", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch("wrong result", want, got);
            end
        end
        if (in_valid && !in_stall)
        begin
            compute_codec_results(cmd_t'(cmd), value, in_byte, buffer_end);
            if (use_typed)
                pending_results.push_back(typed_want);
            else
                for (i = 0; i < model_count; i++)
                    pending_results.push_back(model_out[i]);
        end
    end

    initial
    begin : watchdog
        int idle_count;
        idle_count = 0;
        while (idle_count < StallLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        int seg_left;
        int seg_mode;
        int pat_cnt;
        hold_left = 0;
        seg_left = 0;
        seg_mode = 0;
        pat_cnt = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_left = HoldCycles;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                pat_cnt++;
                case (seg_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ((pat_cnt % 5) < 2);
                endcase
            end
        end
    end

    task automatic pause_input(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            cmd <= 1'($urandom_range(0, 1));
            value <= {$urandom, $urandom};
            in_byte <= 8'($urandom);
            buffer_end <= 1'($urandom_range(0, 1));
            use_typed = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input cmd_t c, input logic [ValueW-1:0] v, input logic [7:0] b,
                             input logic e, input logic typed, input codec_result_t want);
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        in_byte <= b;
        buffer_end <= e;
        use_typed = typed;
        typed_want = want;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic offer_item(input cmd_t c, input logic [ValueW-1:0] v, input logic [7:0] b,
                              input logic e, input logic typed, input codec_result_t want);
        if (burst_left == 0)
        begin
            pause_input(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_item(c, v, b, e, typed, want);
        items_offered++;
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        use_typed = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic set_limit(input logic lim);
        logic [DataW-1:0] data;
        wait_for_idle();
        data = $urandom;
        data[0] = lim;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_LIMIT_ADDR;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        limit32 = lim;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin : stimulus
        stim_row_t         row;
        logic [ValueW-1:0] v;
        logic [6:0]        pay;
        logic              cont;
        int                phase;
        int                phase_end;
        int                r;
        int                w;
        int                len;
        int                sel;
        int                i;
        logic              held;
        logic              paused;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cmd = CMD_ENCODE;
        value = '0;
        in_byte = '0;
        buffer_end = 1'b0;
        use_typed = 1'b0;
        typed_want = '0;
        hold_pending = 1'b0;
        dec_acc = '0;
        dec_seen = '0;
        limit32 = 1'b0;
        mismatches = 0;
        items_offered = 0;
        burst_left = 0;
        held = 1'b0;
        paused = 1'b0;

        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0,
            1, 1'b1, make_result(KIND_DEC_OUT, 8'h00, 64'd0, 4'd1, STATUS_OK, 1'b1)));
        directed_rows.push_back(stim_row(1'b0, CMD_ENCODE, 64'd0, 8'hFF, 1'b1, 1, 1'b1,
            make_result(KIND_ENC_BYTE, 8'h00, 64'd0, 4'd0, STATUS_OK, 1'b1)));
        directed_rows.push_back(stim_row(1'b0, CMD_ENCODE, 64'd127, 8'h00, 1'b0, 1, 1'b1,
            make_result(KIND_ENC_BYTE, 8'h7F, 64'd0, 4'd0, STATUS_OK, 1'b1)));
        directed_rows.push_back(stim_row(1'b0, CMD_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
            1'b0, 1, 1'b0, '0));
        directed_rows.push_back(stim_row(1'b0, CMD_ENCODE, 64'h8000_0000_0000_0000, 8'h5A,
            1'b1, 1, 1'b0, '0));
        // terminating byte together with buffer end
        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'd0, 8'h7F, 1'b1, 1, 1'b1,
            make_result(KIND_DEC_OUT, 8'h00, 64'd127, 4'd1, STATUS_OK, 1'b1)));
        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'd0, 8'h80, 1'b1, 1, 1'b1,
            make_result(KIND_DEC_OUT, 8'h00, 64'd0, 4'd0, STATUS_TRUNCATED, 1'b1)));
        // tenth byte above one
        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'd0, 8'h80, 1'b0, 9, 1'b0, '0));
        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'd0, 8'h02, 1'b0, 1, 1'b1,
            make_result(KIND_DEC_OUT, 8'h00, 64'd0, 4'd0, STATUS_OVERFLOW, 1'b1)));
        // too long wins over truncation
        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'd0, 8'hFF, 1'b0, 9, 1'b0, '0));
        directed_rows.push_back(stim_row(1'b0, CMD_DECODE, 64'd0, 8'hFF, 1'b1, 1, 1'b1,
            make_result(KIND_DEC_OUT, 8'h00, 64'd0, 4'd0, STATUS_TOO_LONG, 1'b1)));
        // value of 2^32 in 32-bit mode
        directed_rows.push_back(stim_row(1'b1, CMD_DECODE, 64'd0, 8'h80, 1'b0, 4, 1'b0, '0));
        directed_rows.push_back(stim_row(1'b1, CMD_DECODE, 64'd0, 8'h10, 1'b0, 1, 1'b1,
            make_result(KIND_DEC_OUT, 8'h00, 64'd0, 4'd0, STATUS_OVERFLOW, 1'b1)));

        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;

        set_limit(1'b0);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.limit32 != limit32)
                set_limit(row.limit32);
            for (r = 0; r < row.reps; r++)
                offer_item(row.cmd, row.value, row.in_byte, row.buffer_end,
                           row.typed && (r == row.reps - 1), row.want);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            set_limit(phase != 1);
            phase_end = items_offered + PhaseItems;
            while (items_offered < phase_end)
            begin
                if (phase == 0 && !held && items_offered + 70 < phase_end)
                begin
                    hold_pending = 1'b1;
                    held = 1'b1;
                end
                if (phase == 1 && !paused && items_offered + 50 < phase_end)
                begin
                    wait_for_idle();
                    paused = 1'b1;
                end
                sel = $urandom_range(0, 99);
                if (sel < 30)
                begin
                    w = $urandom_range(0, 64);
                    v = {$urandom, $urandom};
                    if (w < 64)
                        v = v & ((64'd1 << w) - 64'd1);
                    offer_item(CMD_ENCODE, v, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (sel < 80)
                begin
                    len = $urandom_range(1, MaxBytes);
                    for (i = 0; i < len; i++)
                    begin
                        cont = (i < len - 1);
                        pay = 7'($urandom_range(0, 127));
                        if (i == MaxBytes - 1 && $urandom_range(0, 3) != 0)
                            pay = 7'($urandom_range(0, 1));
                        offer_item(CMD_DECODE, {$urandom, $urandom}, {cont, pay},
                                   cont ? 1'b0 : 1'($urandom_range(0, 1)), 1'b0, '0);
                    end
                end
                else if (sel < 90)
                    offer_item(CMD_DECODE, {$urandom, $urandom}, 8'($urandom),
                               ($urandom_range(0, 9) == 0), 1'b0, '0);
                else
                begin
                    len = $urandom_range(1, MaxBytes);
                    for (i = 0; i < len; i++)
                        offer_item(CMD_DECODE, {$urandom, $urandom},
                                   {1'b1, 7'($urandom)},
                                   (i == len - 1) && $urandom_range(0, 1), 1'b0, '0);
                end
            end
        end

        wait_for_idle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
design/uvc_pkg.sv
design/uvc_enc_unit.sv
design/uvc_dec_unit.sv
design/uvarint_codec.sv
verif/testbench.sv
